@@ src/cfr_pkg.sv @@
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared widths, reset constants and the structs that travel between the
// front, the command queue and the back of the checked frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned CntW  = 6;

  localparam logic [DataW-1:0] SumInit  = 8'd1;
  localparam logic [CntW-1:0]  LenReset = 6'd16;

  // One command per checksum byte: deliver a stored frame, or report an error.
  typedef struct packed {
    logic            ok;
    logic            bank;
    logic [CntW-1:0] len;
  } cmd_t;

  // Pulses when the back has moved the final byte of a bank out of the memory.
  typedef struct packed {
    logic valid;
    logic bank;
  } done_t;

endpackage : cfr_pkg

`default_nettype wire

@@ src/cfr_ram.sv @@
// ----------------------------------------------------------------------------
// cfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : cfr_ram

`default_nettype wire

@@ src/cfr_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// cfr_cmd_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_i,
  input  wire cfr_pkg::cmd_t wdata_i,
  output      logic          full_o,
  input  wire logic          rd_i,
  output      cfr_pkg::cmd_t rdata_o,
  output      logic          empty_o
);

  cfr_pkg::cmd_t mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          do_wr, do_rd;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_wr;
    rd_ptr_d = rd_ptr_q ^ do_rd;
    count_d  = count_q + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule : cfr_cmd_fifo

`default_nettype wire

@@ src/cfr_front.sv @@
// ----------------------------------------------------------------------------
// cfr_front
// Accepts received bytes, stores payload into the current memory bank, keeps
// the running checksum and issues one command per checksum byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_front #(
  parameter int unsigned MaxFrame = 63,
  parameter int unsigned IdxW     = 6
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [cfr_pkg::CntW-1:0]    frame_len_i,
  input  wire logic                        push_i,
  input  wire logic [cfr_pkg::DataW-1:0]   rx_byte_i,
  output      logic                        full_o,
  output      logic                        we_o,
  output      logic [IdxW:0]               waddr_o,
  output      logic [cfr_pkg::DataW-1:0]   wdata_o,
  output      logic                        cmd_wr_o,
  output      cfr_pkg::cmd_t               cmd_o,
  input  wire logic                        cmd_full_i,
  input  wire cfr_pkg::done_t              done_i
);

  localparam logic [cfr_pkg::CntW-1:0] MaxLen = cfr_pkg::CntW'(MaxFrame);

  logic [cfr_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [cfr_pkg::DataW-1:0] sum_q, sum_d;
  logic                      bank_q, bank_d;
  logic [1:0]                busy_q, busy_d;
  logic [cfr_pkg::CntW-1:0]  len_eff;
  logic                      is_chk, accept, match;

  always_comb begin
    priority if (frame_len_i == '0) begin
      len_eff = cfr_pkg::CntW'(1);
    end else if (frame_len_i > MaxLen) begin
      len_eff = MaxLen;
    end else begin
      len_eff = frame_len_i;
    end
  end

  // A count at or past the length means this beat is the checksum byte.
  assign is_chk = (cnt_q >= len_eff);
  // Payload waits while the back still drains this bank; a checksum waits for queue room.
  assign full_o = is_chk ? cmd_full_i : busy_q[bank_q];
  assign accept = push_i && !full_o;
  assign match  = (rx_byte_i == sum_q);

  assign we_o    = accept && !is_chk;
  assign waddr_o = {bank_q, cnt_q[IdxW-1:0]};
  assign wdata_o = rx_byte_i;

  assign cmd_wr_o  = accept && is_chk;
  assign cmd_o.ok   = match;
  assign cmd_o.bank = bank_q;
  assign cmd_o.len  = len_eff;

  always_comb begin
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    bank_d = bank_q;
    busy_d = busy_q;
    if (done_i.valid) begin
      busy_d[done_i.bank] = 1'b0;
    end
    if (accept) begin
      if (is_chk) begin
        cnt_d = '0;
        sum_d = cfr_pkg::SumInit;
        if (match) begin
          busy_d[bank_q] = 1'b1;
          bank_d         = !bank_q;
        end
      end else begin
        cnt_d = cnt_q + 1'b1;
        // 7 * sum is formed as 8 * sum - sum.
        sum_d = {sum_q[cfr_pkg::DataW-4:0], 3'b000} - sum_q + rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= cfr_pkg::SumInit;
      bank_q <= 1'b0;
      busy_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
    end
  end

endmodule : cfr_front

`default_nettype wire

@@ src/cfr_back.sv @@
// ----------------------------------------------------------------------------
// cfr_back
// Takes commands from the queue and delivers either the stored frame, one
// memory read per result beat, or a single error beat.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_back #(
  parameter int unsigned IdxW = 6
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire cfr_pkg::cmd_t             cmd_i,
  input  wire logic                      cmd_empty_i,
  output      logic                      cmd_rd_o,
  output      logic                      re_o,
  output      logic [IdxW:0]             raddr_o,
  input  wire logic [cfr_pkg::DataW-1:0] rdata_i,
  output      cfr_pkg::done_t            done_o,
  output      logic                      empty_o,
  input  wire logic                      pop_i,
  output      logic [cfr_pkg::DataW-1:0] payload_byte_o,
  output      logic                      frame_ok_o,
  output      logic                      last_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  state_e                    state_q, state_d;
  cfr_pkg::cmd_t             cur_q, cur_d;
  logic [cfr_pkg::CntW-1:0]  idx_q, idx_d;
  logic                      pend_q, pend_d;
  logic                      pend_last_q, pend_last_d;
  logic                      out_vld_q, out_vld_d;
  logic [cfr_pkg::DataW-1:0] out_byte_q, out_byte_d;
  logic                      out_ok_q, out_ok_d;
  logic                      out_last_q, out_last_d;
  logic                      slot_free;

  // A read or an error beat is only started when the output register is empty and no read is in flight.
  assign slot_free = !out_vld_q && !pend_q;

  assign empty_o        = !out_vld_q;
  assign payload_byte_o = out_byte_q;
  assign frame_ok_o     = out_ok_q;
  assign last_o         = out_last_q;
  assign raddr_o        = {cur_q.bank, idx_q[IdxW-1:0]};

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    out_vld_d   = out_vld_q && !pop_i;
    out_byte_d  = out_byte_q;
    out_ok_d    = out_ok_q;
    out_last_d  = out_last_q;
    cmd_rd_o    = 1'b0;
    re_o        = 1'b0;
    done_o      = '0;

    if (pend_q) begin
      pend_d     = 1'b0;
      out_vld_d  = 1'b1;
      out_byte_d = rdata_i;
      out_ok_d   = 1'b1;
      out_last_d = pend_last_q;
      if (pend_last_q) begin
        done_o.valid = 1'b1;
        done_o.bank  = cur_q.bank;
        state_d      = StIdle;
      end
    end

    unique case (state_q)
      StIdle: begin
        if (!cmd_empty_i && slot_free) begin
          cmd_rd_o = 1'b1;
          cur_d    = cmd_i;
          idx_d    = '0;
          if (cmd_i.ok) begin
            state_d = StRun;
          end else begin
            out_vld_d  = 1'b1;
            out_byte_d = '0;
            out_ok_d   = 1'b0;
            out_last_d = 1'b1;
          end
        end
      end
      StRun: begin
        if (slot_free) begin
          re_o        = 1'b1;
          pend_d      = 1'b1;
          pend_last_d = ((idx_q + 1'b1) == cur_q.len);
          idx_d       = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    idx_q       <= idx_d;
    pend_last_q <= pend_last_d;
    out_byte_q  <= out_byte_d;
    out_ok_q    <= out_ok_d;
    out_last_q  <= out_last_d;
  end

endmodule : cfr_back

`default_nettype wire

@@ src/checked_frame_receiver.sv @@
// Receives fixed-length frames one byte per beat: frame_len payload bytes (0 counts
// as 1, and more than MAX_FRAME as MAX_FRAME) and then a checksum byte (start at 1,
// sum = 7 * sum + byte, modulo 256). After a checksum byte the frame is delivered
// from a two-bank memory. Each result beat needs a registered memory read, then the
// output register, which must be popped before the next read starts. The last beat is
// marked. A wrong checksum gives a single error beat instead. The banks alternate
// between good frames, so the next frame is taken while the previous one drains. The
// payload of the frame after that waits (full high) until its bank has been read out,
// and a checksum byte waits while two commands are already queued. The memory needs no
// clearing pass.
// ----------------------------------------------------------------------------
// checked_frame_receiver
// Top level: configuration register, front, command queue, frame memory, back.
// ----------------------------------------------------------------------------
`default_nettype none

module checked_frame_receiver #(
  parameter int unsigned MAX_FRAME = 63
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output      logic                        cfg_ready_o,
  input  wire logic [cfr_pkg::CntW-1:0]    cfg_data_i,
  input  wire logic                        push,
  output      logic                        full,
  input  wire logic [cfr_pkg::DataW-1:0]   rx_byte_i,
  output      logic                        empty,
  input  wire logic                        pop,
  output      logic [cfr_pkg::DataW-1:0]   payload_byte_o,
  output      logic                        frame_ok_o,
  output      logic                        last_o
);

  localparam int unsigned IdxW  = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
  localparam int unsigned Depth = 2 * (2 ** IdxW);

  logic [cfr_pkg::CntW-1:0]  frame_len_q;
  logic                      we, re;
  logic [IdxW:0]             waddr, raddr;
  logic [cfr_pkg::DataW-1:0] wdata, rdata;
  logic                      cmd_wr, cmd_rd, cmd_full, cmd_empty;
  cfr_pkg::cmd_t             cmd_in, cmd_out;
  cfr_pkg::done_t            done;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= cfr_pkg::LenReset;
    end else if (cfg_valid_i) begin
      frame_len_q <= cfg_data_i;
    end
  end

  cfr_front #(
    .MaxFrame (MAX_FRAME),
    .IdxW     (IdxW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_len_i (frame_len_q),
    .push_i      (push),
    .rx_byte_i   (rx_byte_i),
    .full_o      (full),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .cmd_wr_o    (cmd_wr),
    .cmd_o       (cmd_in),
    .cmd_full_i  (cmd_full),
    .done_i      (done)
  );

  cfr_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_wr),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .rd_i    (cmd_rd),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  cfr_ram #(
    .Width (cfr_pkg::DataW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cfr_back #(
    .IdxW (IdxW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_out),
    .cmd_empty_i    (cmd_empty),
    .cmd_rd_o       (cmd_rd),
    .re_o           (re),
    .raddr_o        (raddr),
    .rdata_i        (rdata),
    .done_o         (done),
    .empty_o        (empty),
    .pop_i          (pop),
    .payload_byte_o (payload_byte_o),
    .frame_ok_o     (frame_ok_o),
    .last_o         (last_o)
  );

endmodule : checked_frame_receiver

`default_nettype wire
